@@ hdl/sisr_pkg.sv @@
// ============================================================================
// Stable insertion sort package
// Shared payload types, default sizes and controller/datapath interface
// structures for the stable insertion sort core.
// ============================================================================
package sisr_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int TAG_W        = 6;

    typedef struct packed {
        logic [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0] record_tag;
        logic             last_item;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             last_result;
        logic             overflow;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic drop_item;
        logic scan_read;
        logic write_new;
        logic write_shift;
        logic out_read;
        logic out_load;
        logic batch_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_last;
        logic full;
        logic slot_zero;
        logic key_greater;
        logic last_flag;
        logic out_free;
        logic out_done;
    } dp_status_t;

endpackage

@@ hdl/stable_insertion_sort_records_core.sv @@
// ============================================================================
// Stable insertion sort core
// Collects a batch of records and returns them in stable ascending key order.
// ============================================================================
// Records enter on the s_ channel (valid/ready); each transaction carries a
// key, a tag and a last flag. Each record is inserted as it arrives into a
// record memory with one read and one write port: stored records with a
// strictly greater key move up one place, so equal keys keep arrival order.
// Each record moved is a memory read followed by a compare and a write. A
// record that arrives while the store is full is dropped without an insertion
// step. The input is not ready again until the insertion ends.
// When the last record has been inserted, the batch is read out on the m_
// channel, each result read from memory into the result register; the final
// result carries last_result, and every result of the batch carries overflow
// if records arrived while the store was full (those records are dropped).
// A stalled receiver holds the result register and pauses the read-out; the
// next batch can start while the final result still waits.
// Reset empties the store and the result register; no clearing pass is needed.
// ============================================================================
module stable_insertion_sort_records_core #(
    parameter int CAPACITY = sisr_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sisr_pkg::KEY_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sisr_pkg::in_item_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sisr_pkg::out_item_t  m_payload
);

    sisr_pkg::ctrl_cmd_t  cmd;
    sisr_pkg::dp_status_t status;

    sisr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sisr_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ hdl/sisr_ctrl.sv @@
// ============================================================================
// Stable insertion sort controller
// One-hot state machine that sequences record insertion and batch read-out.
// ============================================================================
module sisr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sisr_pkg::dp_status_t  status,
    output sisr_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_CMP    = 5'b00100,
        ST_OUT_RD = 5'b01000,
        ST_OUT_LD = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (status.full) begin
                        cmd.drop_item = 1'b1;
                        state_next    = status.in_last ? ST_OUT_RD : ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (status.slot_zero) begin
                    cmd.write_new = 1'b1;
                    state_next    = status.last_flag ? ST_OUT_RD : ST_IDLE;
                end else begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.key_greater) begin
                    cmd.write_shift = 1'b1;
                    state_next      = ST_SCAN;
                end else begin
                    cmd.write_new = 1'b1;
                    state_next    = status.last_flag ? ST_OUT_RD : ST_IDLE;
                end
            end
            ST_OUT_RD: begin
                if (status.out_free) begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_OUT_LD;
                end
            end
            ST_OUT_LD: begin
                cmd.out_load = 1'b1;
                if (status.out_done) begin
                    cmd.batch_clear = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_blocks_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !status.full) |=> !s_ready)
        else $error("Input accepted again before the insertion finished.");
`endif

endmodule

@@ hdl/sisr_datapath.sv @@
// ============================================================================
// Stable insertion sort datapath
// Record memory, insertion slot and fill counters, and the result register.
// ============================================================================
module sisr_datapath #(
    parameter int CAPACITY = sisr_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sisr_pkg::KEY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sisr_pkg::in_item_t    s_payload,
    output sisr_pkg::out_item_t   m_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  sisr_pkg::ctrl_cmd_t   cmd,
    output sisr_pkg::dp_status_t  status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int REC_W = KEY_BITS + sisr_pkg::TAG_W;
    localparam int EXT_W = KEY_BITS + sisr_pkg::KEY_W;

    logic [REC_W-1:0]             rec_mem [CAPACITY];
    logic [REC_W-1:0]             rd_data_reg;
    logic [KEY_BITS-1:0]          key_new_reg;
    logic [sisr_pkg::TAG_W-1:0]   tag_new_reg;
    logic                         last_reg;
    logic [IDX_W-1:0]             slot_reg;
    logic [CNT_W-1:0]             fill_reg;
    logic                         drop_reg;
    logic [IDX_W-1:0]             out_idx_reg;
    sisr_pkg::out_item_t          m_payload_reg;
    logic                         m_valid_reg;

    logic [EXT_W-1:0]             in_key_ext;
    logic [EXT_W-1:0]             out_key_ext;
    logic [KEY_BITS-1:0]          rd_key;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [REC_W-1:0]             mem_wdata;
    logic                         mem_re;
    logic [IDX_W-1:0]             mem_raddr;

    assign in_key_ext  = {{KEY_BITS{1'b0}}, s_payload.sort_key};
    assign rd_key      = rd_data_reg[REC_W-1:sisr_pkg::TAG_W];
    assign out_key_ext = {{sisr_pkg::KEY_W{1'b0}}, rd_key};

    assign mem_we    = cmd.write_new || cmd.write_shift;
    assign mem_waddr = slot_reg;
    assign mem_wdata = cmd.write_shift ? rd_data_reg : {key_new_reg, tag_new_reg};
    assign mem_re    = cmd.scan_read || cmd.out_read;
    assign mem_raddr = cmd.out_read ? out_idx_reg : slot_reg - IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rec_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= rec_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            key_new_reg <= in_key_ext[KEY_BITS-1:0];
            tag_new_reg <= s_payload.record_tag;
        end
        if (cmd.out_load) begin
            m_payload_reg.sorted_key  <= out_key_ext[sisr_pkg::KEY_W-1:0];
            m_payload_reg.sorted_tag  <= rd_data_reg[sisr_pkg::TAG_W-1:0];
            m_payload_reg.last_result <= status.out_done;
            m_payload_reg.overflow    <= drop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= 1'b0;
            slot_reg    <= '0;
            fill_reg    <= '0;
            drop_reg    <= 1'b0;
            out_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                last_reg    <= s_payload.last_item;
                slot_reg    <= fill_reg[IDX_W-1:0];
                out_idx_reg <= '0;
            end
            if (cmd.drop_item) begin
                drop_reg <= 1'b1;
            end
            if (cmd.write_shift) begin
                slot_reg <= slot_reg - IDX_W'(1);
            end
            if (cmd.write_new) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                out_idx_reg <= out_idx_reg + IDX_W'(1);
            end
            if (cmd.batch_clear) begin
                fill_reg <= '0;
                drop_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.in_last     = s_payload.last_item;
        status.full        = (fill_reg == CNT_W'(CAPACITY));
        status.slot_zero   = (slot_reg == '0);
        status.key_greater = (rd_key > key_new_reg);
        status.last_flag   = last_reg;
        status.out_free    = !m_valid_reg || m_ready;
        status.out_done    = ({1'b0, out_idx_reg} + (IDX_W + 1)'(1))
                             == (IDX_W + 1)'(fill_reg);
    end

    assign m_payload = m_payload_reg;
    assign m_valid   = m_valid_reg;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("Fill count exceeds the store capacity.");

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_new |-> !status.full)
        else $error("Record written into a full store.");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg)
        else $error("Result register loaded while a result is still pending.");
`endif

endmodule

@@ test/sort_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Sorted record checker
// Watches both channels of the stable insertion sort core, keeps its own
// sorted store of the current batch and compares every result transaction
// with the oldest expected record.
// ============================================================================
module sort_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  sisr_pkg::in_item_t   s_payload,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  sisr_pkg::out_item_t  m_payload,
    output int                   fail_count,
    output int                   pending_results
);

    localparam logic [sisr_pkg::KEY_W-1:0] KEY_MASK =
        (sisr_pkg::KEY_BITS_DEF >= sisr_pkg::KEY_W) ? {sisr_pkg::KEY_W{1'b1}} :
        sisr_pkg::KEY_W'((64'd1 << sisr_pkg::KEY_BITS_DEF) - 64'd1);

    logic [sisr_pkg::KEY_W-1:0] held_keys [sisr_pkg::CAPACITY_DEF];
    logic [sisr_pkg::TAG_W-1:0] held_tags [sisr_pkg::CAPACITY_DEF];
    int                         held_count;
    logic                       record_lost;
    sisr_pkg::out_item_t        sorted_queue [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        held_count      = 0;
        record_lost     = 1'b0;
    end

    task automatic insert_record(input sisr_pkg::in_item_t rec);
        int                         slot;
        logic [sisr_pkg::KEY_W-1:0] key;
        key = rec.sort_key & KEY_MASK;
        if (held_count >= sisr_pkg::CAPACITY_DEF) begin
            record_lost = 1'b1;
        end else begin
            slot = held_count;
            while (slot > 0 && held_keys[slot-1] > key) begin
                held_keys[slot] = held_keys[slot-1];
                held_tags[slot] = held_tags[slot-1];
                slot--;
            end
            held_keys[slot] = key;
            held_tags[slot] = rec.record_tag;
            held_count++;
        end
    endtask

    task automatic flush_batch();
        sisr_pkg::out_item_t res;
        for (int k = 0; k < held_count; k++) begin
            res.sorted_key  = held_keys[k];
            res.sorted_tag  = held_tags[k];
            res.last_result = (k == held_count - 1);
            res.overflow    = record_lost;
            sorted_queue.push_back(res);
        end
        held_count  = 0;
        record_lost = 1'b0;
    endtask

    task automatic compare_result(input sisr_pkg::out_item_t got);
        sisr_pkg::out_item_t want;
        if (sorted_queue.size() == 0) begin
            $error("unexpected result: key %0d tag %0d", got.sorted_key, got.sorted_tag);
            fail_count++;
        end else begin
            want = sorted_queue.pop_front();
            if (got.sorted_key !== want.sorted_key) begin
                $error("sorted_key: expected %0d, actual %0d", want.sorted_key, got.sorted_key);
                fail_count++;
            end
            if (got.sorted_tag !== want.sorted_tag) begin
                $error("sorted_tag: expected %0d, actual %0d", want.sorted_tag, got.sorted_tag);
                fail_count++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0b, actual %0b",
                       want.last_result, got.last_result);
                fail_count++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count  = 0;
            record_lost = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                compare_result(m_payload);
            end
            if (s_valid && s_ready) begin
                insert_record(s_payload);
                if (s_payload.last_item) begin
                    flush_batch();
                end
            end
        end
        pending_results = sorted_queue.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Stable insertion sort core testbench
// Sends directed and random batches of records with bursty input and a
// varying receiver stall pattern; a separate checker predicts and compares.
// ============================================================================
module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 330;

    typedef enum {KEYS_FULL, KEYS_NARROW, KEYS_EXTREME} key_mode_t;
    typedef enum {RX_FREE, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    sisr_pkg::in_item_t   s_payload = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    sisr_pkg::out_item_t  m_payload;

    int         fail_count;
    int         pending_results;
    int         cycle_count = 0;
    int         burst_left  = 0;
    int         records_sent = 0;
    rx_mode_t   rx_mode     = RX_FREE;
    int         rx_mode_left = 0;
    int         rx_phase    = 0;

    stable_insertion_sort_records_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    sort_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver changes its stall pattern from time to time.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(20, 150);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            rx_phase <= rx_phase + 1;
            case (rx_mode)
                RX_FREE:    m_ready <= 1'b1;
                RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                RX_QUARTER: m_ready <= (rx_phase % 4 == 0);
                default:    m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_record(input logic [sisr_pkg::KEY_W-1:0] key,
                               input logic [sisr_pkg::TAG_W-1:0] tag,
                               input logic last);
        int gap;
        s_payload <= '{sort_key: key, record_tag: tag, last_item: last};
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        records_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_batch(input int len, input key_mode_t mode);
        logic [sisr_pkg::KEY_W-1:0] key;
        for (int i = 0; i < len; i++) begin
            case (mode)
                KEYS_NARROW:  key = sisr_pkg::KEY_W'($urandom_range(0, 7));
                KEYS_EXTREME: key = ($urandom_range(0, 1) == 0) ? '0 : '1;
                default:      key = sisr_pkg::KEY_W'($urandom_range(0, 65535));
            endcase
            send_record(key, sisr_pkg::TAG_W'($urandom_range(0, 63)), i == len - 1);
        end
    endtask

    initial begin
        int random_start;
        int len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_record(16'hFFFF, 6'd63, 1'b1);

        send_record(16'd5,     6'd1, 1'b0);
        send_record(16'd0,     6'd2, 1'b0);
        send_record(16'd5,     6'd3, 1'b0);
        send_record(16'hFFFF,  6'd4, 1'b0);
        send_record(16'd0,     6'd5, 1'b0);
        send_record(16'd5,     6'd6, 1'b1);

        send_record(16'd40000, 6'd10, 1'b0);
        send_record(16'd30000, 6'd11, 1'b0);
        send_record(16'd20000, 6'd12, 1'b0);
        send_record(16'd10000, 6'd13, 1'b1);

        send_record(16'h5555, 6'h2A, 1'b0);
        send_record(16'hAAAA, 6'h15, 1'b0);
        send_record(16'hFFFE, 6'd0,  1'b1);

        send_record(16'h8000, 6'd20, 1'b0);
        send_record(16'h8000, 6'd21, 1'b0);
        send_record(16'h8000, 6'd22, 1'b0);
        send_record(16'h8000, 6'd23, 1'b1);

        // A batch that fills the store exactly, then one whose last record is dropped.
        random_start = records_sent;
        send_batch(sisr_pkg::CAPACITY_DEF, KEYS_FULL);
        send_batch(sisr_pkg::CAPACITY_DEF + 1, KEYS_NARROW);

        while (records_sent - random_start < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 9) == 0)
                ? $urandom_range(sisr_pkg::CAPACITY_DEF, sisr_pkg::CAPACITY_DEF + 4)
                : $urandom_range(1, 12);
            send_batch(len, key_mode_t'($urandom_range(0, 2)));
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (pending_results == 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sisr_pkg.sv
hdl/sisr_ctrl.sv
hdl/sisr_datapath.sv
hdl/stable_insertion_sort_records_core.sv
test/sort_checker.sv
test/testbench.sv
